[sv/skvt_pkg.sv]
// skvt_pkg: shared types and constants for the sorted key/value table.
// Holds operation codes, sequencer states and the memory control struct.
// No dependencies.
package skvt_pkg;

  localparam int FUNC_W     = 2;
  localparam int KEY_PORT_W = 32;
  localparam int VAL_PORT_W = 32;
  localparam int CNT_PORT_W = 5;
  localparam int CAP_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SKEY,
    ST_SCMP,
    ST_FKEY,
    ST_FCHK,
    ST_AWR,
    ST_SHRD,
    ST_SHWR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic ord_we;
    logic kv_we;
  } mem_ctl_t;

endpackage

[sv/skvt_order_mem.sv]
// skvt_order_mem: slot order array, one write and one registered read port.
// Entries never written read back as their own index (identity at reset).
// Depends on skvt_pkg.
module skvt_order_mem import skvt_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [AW-1:0]    rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.ord_we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ord_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= valid_r[raddr] ? mem[raddr] : raddr;
  end

  assign rdata = rdata_r;

endmodule

[sv/skvt_kv_store.sv]
// skvt_kv_store: key and value memories indexed by slot number.
// One write port and one registered read port shared by both arrays.
// Depends on skvt_pkg.
module skvt_kv_store import skvt_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  mem_ctl_t               ctl,
  input  logic [AW-1:0]          waddr,
  input  logic [KEY_WIDTH-1:0]   wkey,
  input  logic [VALUE_WIDTH-1:0] wval,
  input  logic [AW-1:0]          raddr,
  output logic [KEY_WIDTH-1:0]   rkey,
  output logic [VALUE_WIDTH-1:0] rval
);

  logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
  logic [KEY_WIDTH-1:0]   rkey_r;
  logic [VALUE_WIDTH-1:0] rval_r;

  always_ff @(posedge clk) begin
    if (ctl.kv_we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
    rkey_r <= key_mem[raddr];
    rval_r <= val_mem[raddr];
  end

  assign rkey = rkey_r;
  assign rval = rval_r;

endmodule

[sv/skvt_seq.sv]
// skvt_seq: operation sequencer with one shared key comparator.
// Runs binary search, hit check, slot allocation and order shifting.
// Depends on skvt_pkg; drives skvt_order_mem and skvt_kv_store ports.
module skvt_seq import skvt_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = $clog2(DEPTH),
  parameter int CW          = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  func_t                  func,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [CW-1:0]          cap_eff,
  input  logic                   out_free,
  output logic                   idle,
  output logic                   done,
  output logic                   res_ok,
  output logic [VALUE_WIDTH-1:0] res_val,
  output logic [CW-1:0]          res_cnt,
  output mem_ctl_t               ctl,
  output logic [AW-1:0]          ord_raddr,
  output logic [AW-1:0]          ord_waddr,
  output logic [AW-1:0]          ord_wdata,
  input  logic [AW-1:0]          ord_rdata,
  output logic [AW-1:0]          kv_raddr,
  output logic [AW-1:0]          kv_waddr,
  output logic [KEY_WIDTH-1:0]   kv_wkey,
  output logic [VALUE_WIDTH-1:0] kv_wval,
  input  logic [KEY_WIDTH-1:0]   kv_rkey,
  input  logic [VALUE_WIDTH-1:0] kv_rval
);

  state_t                 state_r, state_nxt;
  func_t                  func_r, func_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          lo_r, lo_nxt;
  logic [CW-1:0]          hi_r, hi_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          mid_r, mid_nxt;
  logic [AW-1:0]          slot_r, slot_nxt;
  logic                   ok_r, ok_nxt;
  logic [VALUE_WIDTH-1:0] vout_r, vout_nxt;

  logic [CW:0]   sum;
  logic [AW-1:0] mid_c;
  logic          key_lt, key_eq;
  logic          lo_lt_hi, lo_lt_cnt, sh_more, ins_full;

  // shared comparator
  assign key_lt = kv_rkey < key_r;
  assign key_eq = kv_rkey == key_r;

  assign sum       = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c     = sum[AW:1];
  assign lo_lt_hi  = lo_r < hi_r;
  assign lo_lt_cnt = lo_r < cnt_r;
  assign ins_full  = !(cnt_r < cap_eff);
  assign sh_more   = (func_r == FN_INSERT) ? (idx_r > lo_r) : ((idx_r + CW'(1)) < cnt_r);

  function automatic state_t disp_state(input func_t f, input logic hit);
    state_t s;
    case (f)
      FN_INSERT: s = hit ? ST_DONE : ST_AWR;
      FN_REMOVE: s = hit ? ST_SHRD : ST_DONE;
      default:   s = ST_DONE;
    endcase
    return s;
  endfunction

  function automatic logic [AW-1:0] cnt_nxt_dec(input logic [CW-1:0] c);
    logic [CW-1:0] d;
    d = c - CW'(1);
    return d[AW-1:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (func == FN_CLEAR || (func == FN_INSERT && ins_full)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (lo_lt_hi) begin
          state_nxt = ST_SKEY;
        end else if (lo_lt_cnt) begin
          state_nxt = ST_FKEY;
        end else begin
          state_nxt = disp_state(func_r, 1'b0);
        end
      end
      ST_SKEY: state_nxt = ST_SCMP;
      ST_SCMP: state_nxt = ST_SRCH;
      ST_FKEY: state_nxt = ST_FCHK;
      ST_FCHK: state_nxt = disp_state(func_r, key_eq);
      ST_AWR:  state_nxt = ST_SHRD;
      ST_SHRD: state_nxt = sh_more ? ST_SHWR : ST_DONE;
      ST_SHWR: state_nxt = ST_SHRD;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    func_nxt  = func_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    idx_nxt   = idx_r;
    mid_nxt   = mid_r;
    slot_nxt  = slot_r;
    ok_nxt    = ok_r;
    vout_nxt  = vout_r;
    ctl       = '0;
    ord_raddr = '0;
    ord_waddr = idx_r[AW-1:0];
    ord_wdata = ord_rdata;
    kv_raddr  = ord_rdata;
    kv_waddr  = ord_rdata;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt = func;
          key_nxt  = key;
          val_nxt  = value;
          lo_nxt   = '0;
          hi_nxt   = cnt_r;
          ok_nxt   = 1'b0;
          vout_nxt = '0;
          if (func == FN_CLEAR) begin
            cnt_nxt = '0;
            ok_nxt  = 1'b1;
          end
        end
      end
      ST_SRCH: begin
        if (lo_lt_hi) begin
          mid_nxt   = mid_c;
          ord_raddr = mid_c;
        end else if (lo_lt_cnt) begin
          ord_raddr = lo_r[AW-1:0];
        end else begin
          ord_raddr = cnt_r[AW-1:0];
        end
      end
      ST_SCMP: begin
        if (key_lt) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hi_nxt = CW'(mid_r);
        end
      end
      ST_FKEY: begin
        slot_nxt = ord_rdata;
      end
      ST_FCHK: begin
        ord_raddr = cnt_r[AW-1:0];
        idx_nxt   = lo_r;
        if (func_r == FN_LOOKUP && key_eq) begin
          ok_nxt   = 1'b1;
          vout_nxt = kv_rval;
        end
      end
      ST_AWR: begin
        slot_nxt = ord_rdata;
        ctl.kv_we = 1'b1;
        idx_nxt  = cnt_r;
      end
      ST_SHRD: begin
        if (func_r == FN_INSERT) begin
          if (sh_more) begin
            ord_raddr = idx_r[AW-1:0] - AW'(1);
          end else begin
            ctl.ord_we = 1'b1;
            ord_waddr  = lo_r[AW-1:0];
            ord_wdata  = slot_r;
            cnt_nxt    = cnt_r + CW'(1);
            ok_nxt     = 1'b1;
          end
        end else begin
          if (sh_more) begin
            ord_raddr = idx_r[AW-1:0] + AW'(1);
          end else begin
            ctl.ord_we = 1'b1;
            ord_waddr  = cnt_nxt_dec(cnt_r);
            ord_wdata  = slot_r;
            cnt_nxt    = cnt_r - CW'(1);
            ok_nxt     = 1'b1;
          end
        end
      end
      ST_SHWR: begin
        ctl.ord_we = 1'b1;
        ord_waddr  = idx_r[AW-1:0];
        ord_wdata  = ord_rdata;
        idx_nxt    = (func_r == FN_INSERT) ? (idx_r - CW'(1)) : (idx_r + CW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    idx_r  <= idx_nxt;
    mid_r  <= mid_nxt;
    slot_r <= slot_nxt;
    ok_r   <= ok_nxt;
    vout_r <= vout_nxt;
  end

  assign idle    = state_r == ST_IDLE;
  assign done    = state_r == ST_DONE;
  assign res_ok  = ok_r;
  assign res_val = vout_r;
  assign res_cnt = cnt_r;
  assign kv_wkey = key_r;
  assign kv_wval = val_r;

endmodule

[sv/sorted_key_value_table_top.sv]
// sorted_key_value_table_top: bounded sorted map with slot indirection.
// Instantiates skvt_seq, skvt_order_mem and skvt_kv_store; uses skvt_pkg.
//
// Usage:
//   Input words (in_func, in_key, in_value_in) use valid/ready. in_func picks
//   insert, lookup, remove or clear. One result word per input word comes out
//   on out_success, out_value_out and out_entry_count under valid/ready.
//   cfg_we/cfg_wdata write the capacity limit; write only while idle.
//   An operation runs binary search steps over the order memory, then a hit
//   check if the search ends inside the entries; insert and remove then move
//   order entries one at a time. Clear and a full-table insert skip the search.
//   in_ready is low while the sequencer works and rises the cycle after the
//   result loads; each search step is limited by the order memory read feeding
//   the key memory and the single comparator.
//   A finished result sits in the output register; the next input word is
//   accepted while it waits, but the sequencer holds its result until the
//   output register is free if the receiver stalls.
//   Reset (synchronous, rst_n low) empties the table, restores the identity
//   slot order and sets the capacity limit to 16. No clearing pass is needed.
module sorted_key_value_table_top import skvt_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic [VAL_PORT_W-1:0] in_value_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_success,
  output logic [VAL_PORT_W-1:0] out_value_out,
  output logic [CNT_PORT_W-1:0] out_entry_count,
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]      cap_r;
  logic [CW-1:0]         cap_eff;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r;
  logic [VAL_PORT_W-1:0] out_val_r;
  logic [CNT_PORT_W-1:0] out_cnt_r;

  logic                   start, idle, done, out_free, out_load;
  logic                   res_ok;
  logic [VALUE_WIDTH-1:0] res_val;
  logic [CW-1:0]          res_cnt;
  logic [63:0]            key_ext, val_ext, res_ext;
  logic [KEY_WIDTH-1:0]   key_w;
  logic [VALUE_WIDTH-1:0] val_w;

  mem_ctl_t               ctl;
  logic [AW-1:0]          ord_raddr, ord_waddr, ord_wdata, ord_rdata;
  logic [AW-1:0]          kv_raddr, kv_waddr;
  logic [KEY_WIDTH-1:0]   kv_wkey, kv_rkey;
  logic [VALUE_WIDTH-1:0] kv_wval, kv_rval;

  assign key_ext = 64'(in_key);
  assign val_ext = 64'(in_value_in);
  assign key_w   = KEY_WIDTH'(key_ext);
  assign val_w   = VALUE_WIDTH'(val_ext);
  assign res_ext = 64'(res_val);

  assign cap_eff = (32'(cap_r) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cap_r);

  assign in_ready = idle;
  assign start    = in_valid && idle;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = done && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r  <= res_ok;
      out_val_r <= VAL_PORT_W'(res_ext);
      out_cnt_r <= CNT_PORT_W'(res_cnt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_ok_r;
  assign out_value_out   = out_val_r;
  assign out_entry_count = out_cnt_r;

  skvt_seq #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (func_t'(in_func)),
    .key       (key_w),
    .value     (val_w),
    .cap_eff   (cap_eff),
    .out_free  (out_free),
    .idle      (idle),
    .done      (done),
    .res_ok    (res_ok),
    .res_val   (res_val),
    .res_cnt   (res_cnt),
    .ctl       (ctl),
    .ord_raddr (ord_raddr),
    .ord_waddr (ord_waddr),
    .ord_wdata (ord_wdata),
    .ord_rdata (ord_rdata),
    .kv_raddr  (kv_raddr),
    .kv_waddr  (kv_waddr),
    .kv_wkey   (kv_wkey),
    .kv_wval   (kv_wval),
    .kv_rkey   (kv_rkey),
    .kv_rval   (kv_rval)
  );

  skvt_order_mem #(
    .DEPTH (DEPTH)
  ) u_order (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  skvt_kv_store #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_kv (
    .clk   (clk),
    .ctl   (ctl),
    .waddr (kv_waddr),
    .wkey  (kv_wkey),
    .wval  (kv_wval),
    .raddr (kv_raddr),
    .rkey  (kv_rkey),
    .rval  (kv_rval)
  );

endmodule

[tb/skvt_table_checker.sv]
// skvt_table_checker: passive checker for the sorted key/value table.
// Keeps a shadow map of the table, predicts one result per input word and
// compares it with the output channel. Uses skvt_pkg.
`timescale 1ns / 100ps
module skvt_table_checker import skvt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic [VAL_PORT_W-1:0] in_value_in,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_success,
  input  logic [VAL_PORT_W-1:0] out_value_out,
  input  logic [CNT_PORT_W-1:0] out_entry_count,
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int TABLE_DEPTH = 16;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic                  success;
    logic [VAL_PORT_W-1:0] value;
    logic [CNT_PORT_W-1:0] count;
  } table_result_t;

  logic [VAL_PORT_W-1:0] shadow_map [logic [KEY_PORT_W-1:0]];
  logic [CAP_W-1:0]      shadow_cap;
  table_result_t         expected_results[$];

  function automatic table_result_t predict_table_op(func_t op, logic [KEY_PORT_W-1:0] key,
                                                     logic [VAL_PORT_W-1:0] value);
    table_result_t r;
    int eff_cap;
    eff_cap = (shadow_cap > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_cap);
    r = '0;
    case (op)
      FN_INSERT: begin
        if (shadow_map.size() < eff_cap && !shadow_map.exists(key)) begin
          shadow_map[key] = value;
          r.success = 1'b1;
        end
      end
      FN_LOOKUP: begin
        if (shadow_map.exists(key)) begin
          r.value   = shadow_map[key];
          r.success = 1'b1;
        end
      end
      FN_REMOVE: begin
        if (shadow_map.exists(key)) begin
          shadow_map.delete(key);
          r.success = 1'b1;
        end
      end
      default: begin
        shadow_map.delete();
        r.success = 1'b1;
      end
    endcase
    r.count = CNT_PORT_W'(shadow_map.size());
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t got;
    table_result_t exp_word;
    if (!rst_n) begin
      shadow_map.delete();
      shadow_cap = CAP_RESET;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_we) shadow_cap = cfg_wdata;
      if (in_valid && in_ready)
        expected_results.push_back(predict_table_op(func_t'(in_func), in_key, in_value_in));
      if (out_valid && out_ready) begin
        got = {out_success, out_value_out, out_entry_count};
        if (expected_results.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("%0t: unexpected result word success=%0b value=%h count=%0d",
                     $realtime, got.success, got.value, got.count);
          fail_count++;
        end else begin
          exp_word = expected_results.pop_front();
          if (got.success !== exp_word.success || got.value !== exp_word.value ||
              got.count !== exp_word.count) begin
            if (fail_count < REPORT_MAX)
              $display("%0t: mismatch success exp %0b got %0b, value exp %h got %h, count exp %0d got %0d",
                       $realtime, exp_word.success, got.success, exp_word.value, got.value,
                       exp_word.count, got.count);
            fail_count++;
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

[tb/tb_sorted_key_value_table_top.sv]
// tb_sorted_key_value_table_top: stimulus and verdict for the sorted key/value table.
// Drives insert/lookup/remove/clear words and capacity writes with random idling;
// checking is done by skvt_table_checker. Uses skvt_pkg.
`timescale 1ns / 100ps
module tb_sorted_key_value_table_top;
  import skvt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int POOL_SIZE      = 24;
  localparam int PHASES         = 10;
  localparam int PHASE_WORDS    = 85;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TIGHT} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func = FN_LOOKUP;
  logic [KEY_PORT_W-1:0] in_key = '0;
  logic [VAL_PORT_W-1:0] in_value_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_success;
  logic [VAL_PORT_W-1:0] out_value_out;
  logic [CNT_PORT_W-1:0] out_entry_count;
  logic                  cfg_we = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata = '0;

  int fail_count;
  int pending;
  int burst_left = 0;
  int idle_cycles = 0;
  int ready_run = 0;
  rx_mode_t ready_mode = RX_OPEN;
  logic [KEY_PORT_W-1:0] key_pool [POOL_SIZE];

  always #5 clk = ~clk;

  sorted_key_value_table_top #(
    .DEPTH      (16),
    .KEY_WIDTH  (32),
    .VALUE_WIDTH(32)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_key         (in_key),
    .in_value_in    (in_value_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_success    (out_success),
    .out_value_out  (out_value_out),
    .out_entry_count(out_entry_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  skvt_table_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_key         (in_key),
    .in_value_in    (in_value_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_success    (out_success),
    .out_value_out  (out_value_out),
    .out_entry_count(out_entry_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // receiver stall pattern: runs of open, coin-flip or tight readiness
  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_mode <= rx_mode_t'($urandom_range(0, 2));
      ready_run  <= $urandom_range(8, 64);
    end else begin
      ready_run <= ready_run - 1;
    end
    case (ready_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(func_t op, logic [KEY_PORT_W-1:0] k, logic [VAL_PORT_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_func     <= op;
    in_key      <= k;
    in_value_in <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // lower valid after the last accepted word and wait for every result
  task automatic drain_table;
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [KEY_PORT_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic run_mix(int n_words, int insert_pct);
    int r;
    func_t op;
    for (int i = 0; i < n_words; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2)                    op = FN_CLEAR;
      else if (r < 2 + insert_pct)  op = FN_INSERT;
      else if (r[0])                op = FN_LOOKUP;
      else                          op = FN_REMOVE;
      send_word(op, pick_key(), $urandom);
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_cap [PHASES];
    int               phase_ins [PHASES];
    phase_cap = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd1, 5'd17, 5'd8, 5'd2, 5'd16, 5'd12};
    phase_ins = '{75, 50, 50, 55, 45, 60, 50, 50, 40, 55};
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'h7FFF_FFFF;
    key_pool[4] = 32'h8000_0000;
    key_pool[5] = 32'hFFFF_FFFE;
    for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, extremes, duplicate, misses, clear
    send_word(FN_LOOKUP, 32'h0000_0000, 32'h0);
    send_word(FN_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(FN_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_word(FN_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    send_word(FN_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    send_word(FN_INSERT, 32'h0000_0000, 32'h0000_0001);
    send_word(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_word(FN_LOOKUP, 32'h0000_0000, 32'h0);
    send_word(FN_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_word(FN_LOOKUP, 32'h8000_0000, 32'h0);
    send_word(FN_LOOKUP, 32'h0000_0001, 32'h0);
    send_word(FN_REMOVE, 32'h8000_0000, 32'h0);
    send_word(FN_LOOKUP, 32'h8000_0000, 32'h0);
    send_word(FN_REMOVE, 32'h8000_0000, 32'h0);
    send_word(FN_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(FN_LOOKUP, 32'h0000_0000, 32'h0);
    send_word(FN_CLEAR,  32'h0000_0000, 32'h0);
    drain_table();

    // full table, then limit lowered below count, then zero limit
    write_capacity(5'd2);
    send_word(FN_INSERT, 32'd5, 32'h1111_1111);
    send_word(FN_INSERT, 32'd3, 32'h2222_2222);
    send_word(FN_INSERT, 32'd9, 32'h3333_3333);
    drain_table();
    write_capacity(5'd1);
    send_word(FN_INSERT, 32'd4, 32'h4444_4444);
    send_word(FN_REMOVE, 32'd5, 32'h0);
    send_word(FN_INSERT, 32'd4, 32'h4444_4444);
    drain_table();
    write_capacity(5'd0);
    send_word(FN_INSERT, 32'd6, 32'h6666_6666);
    drain_table();

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      for (int j = 0; j < 4; j++) key_pool[$urandom_range(6, POOL_SIZE - 1)] = $urandom;
      run_mix(PHASE_WORDS, phase_ins[p]);
      drain_table();
    end

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
sv/skvt_pkg.sv
sv/skvt_order_mem.sv
sv/skvt_kv_store.sv
sv/skvt_seq.sv
sv/sorted_key_value_table_top.sv
tb/skvt_table_checker.sv
tb/tb_sorted_key_value_table_top.sv
